[sv/fdl_pkg.sv]
package fdl_pkg;

    // Fixed widths of the configuration registers.
    localparam int CountBits    = 2;
    localparam int DelayBits    = 22;
    localparam int CfgIndexBits = 1;

    typedef logic [CfgIndexBits-1:0] cfg_index_t;
    typedef logic [CountBits-1:0]    chan_count_t;
    typedef logic [DelayBits-1:0]    delay_q_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t CfgChannelCount = cfg_index_t'(0);
    localparam cfg_index_t CfgDelay        = cfg_index_t'(1);

endpackage

[sv/fractional_delay_line.sv]
// An accepted sample passes through stage 1, stage 2 and the output register before
// result_valid rises. Throughput: one sample per cycle while sample_stall is low; the
// delay memory has one write and two read ports, so the write of a sample and the reads
// of both taps share a single cycle. Reset: asynchronous and active low. After reset
// the block clears all DEPTH rows (16384 by default) of the delay memory, one row per
// cycle, and takes no sample until it is done; configuration writes are taken at any time.
module fractional_delay_line #(
    parameter int DEPTH        = 16384,
    parameter int MAX_CHANNELS = 2,
    parameter int FRAC_BITS    = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration write port.
    input  logic                          cfg_write,
    input  fdl_pkg::cfg_index_t           cfg_index,
    input  fdl_pkg::delay_q_t             cfg_data,

    // Sample input channel.
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          sample_present,
    input  logic                          block_last,

    // Result output channel.
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          block_last_out
);

    // Address of one row of the memory. A row holds the samples of every channel at
    // one write position, so that the clearing pass needs only one row per cycle.
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW     = $clog2(MAX_CHANNELS + 1);
    localparam int ROW_W  = MAX_CHANNELS * SAMPLE_BITS;
    localparam int PW     = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int SUM_W  = SAMPLE_BITS + 3;

    localparam logic [63:0] DelayMax  = 64'(DEPTH - 1) << FRAC_BITS;
    localparam logic [AW-1:0] LastPos = AW'(DEPTH - 1);
    localparam logic signed [PW-1:0]    RoundHalf = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SampleMax = SUM_W'((64'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SampleMin = -SampleMax - SUM_W'(1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // The delay is kept in the form the address and weight logic needs: the
    // read offset DEPTH - I - (f != 0), which lies in 1..DEPTH, and the weight
    // g of the newer tap, which is zero for a whole-sample delay.
    // ------------------------------------------------------------------
    fdl_pkg::chan_count_t     count_reg;
    logic [AW:0]              offset_reg;
    logic [FRAC_BITS:0]       weight_reg;

    logic [63:0]              delay_sat;
    logic [63:0]              delay_int;
    logic [FRAC_BITS-1:0]     delay_frac;
    logic                     frac_nonzero;
    logic [AW:0]              offset_next;
    logic [FRAC_BITS:0]       weight_next;

    always_comb
    begin
        if (64'(cfg_data) > DelayMax)
        begin
            delay_sat = DelayMax;
        end
        else
        begin
            delay_sat = 64'(cfg_data);
        end
        delay_int    = delay_sat >> FRAC_BITS;
        delay_frac   = delay_sat[FRAC_BITS-1:0];
        frac_nonzero = |delay_frac;
        offset_next  = (AW+1)'(64'(DEPTH) - delay_int - 64'(frac_nonzero));
        if (frac_nonzero)
        begin
            weight_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
            weight_next = weight_next - (FRAC_BITS+1)'(delay_frac);
        end
        else
        begin
            weight_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= fdl_pkg::chan_count_t'(1);
            offset_reg <= (AW+1)'(DEPTH);
            weight_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fdl_pkg::CfgChannelCount:
                begin
                    count_reg <= cfg_data[fdl_pkg::CountBits-1:0];
                end
                fdl_pkg::CfgDelay:
                begin
                    offset_reg <= offset_next;
                    weight_reg <= weight_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective channel count: zero counts as one, and anything above the number
    // of channel buffers counts as that number.
    logic [NW-1:0] count_eff;

    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = NW'(1);
        end
        else if (32'(count_reg) > MAX_CHANNELS)
        begin
            count_eff = NW'(MAX_CHANNELS);
        end
        else
        begin
            count_eff = NW'(count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset.
    // ------------------------------------------------------------------
    logic          clear_busy_reg;
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
            if (clear_addr_reg == LastPos)
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves on when the stage after it is
    // empty or moving on itself, so a result waiting at the output does not
    // keep the earlier stages from filling.
    // ------------------------------------------------------------------
    logic st1_valid_reg;
    logic st2_valid_reg;
    logic adv1;
    logic adv2;
    logic adv3;
    logic accept;

    assign adv3         = !result_valid || !result_stall;
    assign adv2         = !st2_valid_reg || adv3;
    assign adv1         = !st1_valid_reg || adv2;
    assign sample_stall = clear_busy_reg || !adv1;
    assign accept       = sample_valid && !sample_stall;

    // ------------------------------------------------------------------
    // Write position, channel position and tap addresses.
    // ------------------------------------------------------------------
    logic [AW-1:0] wpos_reg;
    logic [CW-1:0] chan_reg;
    logic [AW:0]   tap_sum;
    logic [AW-1:0] tap1_addr;
    logic [AW-1:0] tap2_addr;
    logic          frame_end;

    always_comb
    begin
        tap_sum = (AW+1)'(wpos_reg) + offset_reg;
        if (tap_sum >= (AW+1)'(DEPTH))
        begin
            tap1_addr = AW'(tap_sum - (AW+1)'(DEPTH));
        end
        else
        begin
            tap1_addr = AW'(tap_sum);
        end
        if (tap1_addr == LastPos)
        begin
            tap2_addr = '0;
        end
        else
        begin
            tap2_addr = tap1_addr + AW'(1);
        end
        // A channel position at or past the last channel closes the frame, and
        // so does the end of a block.
        frame_end = ((CW+1)'(chan_reg) + (CW+1)'(1) >= (CW+1)'(count_eff)) || block_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            chan_reg <= '0;
        end
        else if (accept && sample_present)
        begin
            if (frame_end)
            begin
                chan_reg <= '0;
                if (wpos_reg == LastPos)
                begin
                    wpos_reg <= '0;
                end
                else
                begin
                    wpos_reg <= wpos_reg + AW'(1);
                end
            end
            else
            begin
                chan_reg <= chan_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Delay memory: one write port and two registered read ports. The new
    // sample is written at the same edge at which both taps are read, so a
    // tap at the write position is forwarded from the sample itself.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] delay_mem [DEPTH];
    logic [ROW_W-1:0] tap1_row_reg;
    logic [ROW_W-1:0] tap2_row_reg;

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            delay_mem[clear_addr_reg] <= '0;
        end
        else if (accept && sample_present)
        begin
            delay_mem[wpos_reg][chan_reg*SAMPLE_BITS +: SAMPLE_BITS] <= sample_in;
        end
        if (accept)
        begin
            tap1_row_reg <= delay_mem[tap1_addr];
            tap2_row_reg <= delay_mem[tap2_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: tap selection, difference and weighting multiply.
    // ------------------------------------------------------------------
    logic                          st1_has_reg;
    logic                          st1_last_reg;
    logic [CW-1:0]                 st1_chan_reg;
    logic                          st1_fwd1_reg;
    logic                          st1_fwd2_reg;
    logic signed [SAMPLE_BITS-1:0] st1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            st1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st1_has_reg    <= sample_present;
            st1_last_reg   <= block_last;
            st1_chan_reg   <= chan_reg;
            st1_fwd1_reg   <= (tap1_addr == wpos_reg);
            st1_fwd2_reg   <= (tap2_addr == wpos_reg);
            st1_sample_reg <= sample_in;
        end
    end

    logic signed [SAMPLE_BITS-1:0] tap1;
    logic signed [SAMPLE_BITS-1:0] tap2;
    logic signed [SAMPLE_BITS:0]   tap_diff;
    logic signed [FRAC_BITS+1:0]   weight_s;
    logic signed [PW-1:0]          prod_next;

    always_comb
    begin
        if (st1_fwd1_reg)
        begin
            tap1 = st1_sample_reg;
        end
        else
        begin
            tap1 = tap1_row_reg[st1_chan_reg*SAMPLE_BITS +: SAMPLE_BITS];
        end
        if (st1_fwd2_reg)
        begin
            tap2 = st1_sample_reg;
        end
        else
        begin
            tap2 = tap2_row_reg[st1_chan_reg*SAMPLE_BITS +: SAMPLE_BITS];
        end
        tap_diff  = (SAMPLE_BITS+1)'(tap2) - (SAMPLE_BITS+1)'(tap1);
        weight_s  = $signed({1'b0, weight_reg});
        prod_next = PW'(weight_s * tap_diff);
    end

    // ------------------------------------------------------------------
    // Stage 2: rounding, accumulation onto the older tap and clamping; a transaction without a sample gives zero.
    // ------------------------------------------------------------------
    logic                          st2_has_reg;
    logic                          st2_last_reg;
    logic signed [SAMPLE_BITS-1:0] st2_tap1_reg;
    logic signed [PW-1:0]          st2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && st1_valid_reg)
        begin
            st2_has_reg  <= st1_has_reg;
            st2_last_reg <= st1_last_reg;
            st2_tap1_reg <= tap1;
            st2_prod_reg <= prod_next;
        end
    end

    logic signed [PW-1:0]          rounded;
    logic signed [PW-1:0]          step;
    logic signed [SUM_W-1:0]       interp_sum;
    logic signed [SAMPLE_BITS-1:0] result_next;

    always_comb
    begin
        // Adding one half and shifting arithmetically rounds to nearest, with
        // ties toward positive infinity.
        rounded    = st2_prod_reg + RoundHalf;
        step       = rounded >>> FRAC_BITS;
        interp_sum = SUM_W'(st2_tap1_reg) + SUM_W'(step);
        if (!st2_has_reg)
        begin
            result_next = '0;
        end
        else if (interp_sum > SampleMax)
        begin
            result_next = SAMPLE_BITS'(SampleMax);
        end
        else if (interp_sum < SampleMin)
        begin
            result_next = SAMPLE_BITS'(SampleMin);
        end
        else
        begin
            result_next = SAMPLE_BITS'(interp_sum);
        end
    end

    // ------------------------------------------------------------------
    // Output register. A result stays here until its transaction completes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (adv3)
        begin
            result_valid <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && st2_valid_reg)
        begin
            sample_out     <= result_next;
            block_last_out <= st2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // No sample is taken while the memory is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> sample_stall)
    else $error("sample accepted during the clearing pass");

    // The end of a frame moves the write position on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample_present && frame_end) |=> (wpos_reg != $past(wpos_reg)))
    else $error("write position did not advance at the end of a frame");

    // A held first stage keeps the tap data it read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st1_valid_reg && !adv1) |=> (st1_valid_reg && $stable(tap1_row_reg)
                                      && $stable(tap2_row_reg)))
    else $error("stalled tap data changed");

    // A result leaving stage 2 shows up at the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st2_valid_reg && adv3) |=> result_valid)
    else $error("result lost between stage 2 and the output register");

endmodule
